[rtl/savs_pkg.sv]
// shared types, constants and helpers for the sign-aligned vector smoother
package savs_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int FracBits  = 14;

  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);
  localparam int FwW  = 12;
  localparam int FhW  = 13;
  localparam int ThrW = 16;
  localparam int CfgW = 16;
  localparam int SumW = 20;
  localparam int LenW = 2 * SumW;
  localparam int MagW = FracBits + 1;
  localparam int CntW = $clog2(MagW + 1);
  localparam int AccW = LenW + 2 * MagW + 2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  typedef logic [31:0] pix_t;

  // one result request handed from the front to the back
  typedef struct packed {
    pix_t [8:0] win;
    logic       rlo_top;
    logic       rlo_mid;
    logic       clo_l;
    logic       clo_m;
    logic       rc_low;
    logic       cc_right;
    logic       last;
    logic       eof;
  } job_t;

  function automatic logic signed [15:0] vx_of(input pix_t p);
    vx_of = p[15:0];
  endfunction

  function automatic logic signed [15:0] vy_of(input pix_t p);
    vy_of = p[31:16];
  endfunction

endpackage

[rtl/savs_front.sv]
// front end: line stores, 3x3 window and result requests in raster order
module savs_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_idx,
  input  logic [savs_pkg::CfgW-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              in_vec_x,
  input  logic [15:0]              in_vec_y,
  output logic                     job_valid,
  input  logic                     job_ready,
  output savs_pkg::job_t           job
);
  import savs_pkg::*;

  localparam logic [1:0] ST_IN   = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [FwW-1:0]  fw_r;
  logic [FhW-1:0]  fh_r;
  logic [ColW-1:0] col_r;
  logic [RowW-1:0] row_r;
  pix_t            cur_r;
  pix_t [8:0]      win_r;
  logic [3:0]      pend_r;
  pix_t            mem_a [MaxWidth];
  pix_t            mem_b [MaxWidth];
  pix_t            top_q, mid_q;

  logic [ColW:0] w_eff;
  logic [RowW:0] h_eff;
  logic          c_last, r_last;

  always_comb begin
    if (fw_r == '0) w_eff = (ColW+1)'(1);
    else if ({1'b0, fw_r} > (FwW+1)'(MaxWidth)) w_eff = (ColW+1)'(MaxWidth);
    else w_eff = (ColW+1)'(fw_r);
    if (fh_r == '0) h_eff = (RowW+1)'(1);
    else if ({1'b0, fh_r} > (FhW+1)'(MaxHeight)) h_eff = (RowW+1)'(MaxHeight);
    else h_eff = (RowW+1)'(fh_r);
  end

  assign c_last = ({1'b0, col_r} + 1'b1) >= w_eff;
  assign r_last = ({1'b0, row_r} + 1'b1) >= h_eff;

  always_ff @(posedge clk) begin
    if (state_r == ST_IN && in_valid) begin
      top_q <= mem_b[col_r];
      mid_q <= mem_a[col_r];
    end
    if (state_r == ST_READ) begin
      mem_b[col_r] <= mid_q;
      mem_a[col_r] <= cur_r;
    end
  end

  // pending requests in emission order: bit0 up-left .. bit3 self
  logic [3:0] sel_oh, rem;
  always_comb begin
    sel_oh = pend_r & (~pend_r + 4'd1);
    rem    = pend_r & ~sel_oh;
  end

  assign in_ready  = (state_r == ST_IN);
  assign job_valid = (state_r == ST_EMIT) && (pend_r != '0);

  always_comb begin
    job.win      = win_r;
    job.rc_low   = sel_oh[2] | sel_oh[3];
    job.cc_right = sel_oh[1] | sel_oh[3];
    job.rlo_top  = job.rc_low ? 1'b0 : (row_r >= RowW'(2));
    job.rlo_mid  = job.rc_low ? (row_r >= RowW'(1)) : 1'b1;
    job.clo_l    = job.cc_right ? 1'b0 : (col_r >= ColW'(2));
    job.clo_m    = job.cc_right ? (col_r >= ColW'(1)) : 1'b1;
    job.last     = (rem == '0);
    job.eof      = sel_oh[3];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IN:   if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EMIT;
      ST_EMIT: if (pend_r == '0 || (job_ready && rem == '0)) state_nxt = ST_IN;
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
      fw_r    <= FwW'(640);
      fh_r    <= FhW'(480);
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
      pend_r  <= '0;
    end else if (cfg_we && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT)) begin
      if (cfg_idx == REG_WIDTH) fw_r <= cfg_data[FwW-1:0];
      else fh_r <= cfg_data[FhW-1:0];
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
      state_r <= ST_IN;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IN && in_valid) begin
        cur_r <= {in_vec_y, in_vec_x};
      end
      if (state_r == ST_READ) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]   <= win_r[k*3+1];
          win_r[k*3+1] <= win_r[k*3+2];
        end
        win_r[2] <= top_q;
        win_r[5] <= mid_q;
        win_r[8] <= cur_r;
        pend_r <= {r_last & c_last, r_last & (col_r != '0),
                   c_last & (row_r != '0), (col_r != '0) & (row_r != '0)};
      end
      if (state_r == ST_EMIT) begin
        if (job_valid && job_ready) pend_r <= rem;
        if (state_nxt == ST_IN) begin
          if (c_last) begin
            col_r <= '0;
            row_r <= r_last ? '0 : row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

[rtl/savs_fifo.sv]
// short request queue between front and back
module savs_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  savs_pkg::job_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output savs_pkg::job_t  rd_data
);
  import savs_pkg::*;

  job_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) buf_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((wr_valid && wr_ready)) - 2'((rd_valid && rd_ready));
    end
  end

endmodule

[rtl/savs_back.sv]
// back end: sign alignment, neighbor sum and bit-serial normalization
module savs_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [savs_pkg::ThrW-1:0] thresh,
  input  logic                      job_valid,
  output logic                      job_ready,
  input  savs_pkg::job_t            job,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               out_x,
  output logic [15:0]               out_y,
  output logic                      out_last_in_run,
  output logic                      out_end_of_frame
);
  import savs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_NX   = 3'd3;
  localparam logic [2:0] ST_NY   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]            state_r;
  job_t                  job_r;
  logic [3:0]            idx_r;
  logic signed [SumW-1:0] ax_r, ay_r;
  logic [LenW-1:0]       len_r, sqy_r;
  logic [AccW-1:0]       pacc_r, sb_r, lq_r, rhs_r;
  logic [MagW-1:0]       res_r, rx_r;
  logic [CntW-1:0]       bit_r;
  logic [15:0]           ox_r, oy_r;

  pix_t ctr, nb;
  logic [3:0] ctr_idx;
  logic signed [15:0] cx, cy, nx, ny;
  logic signed [33:0] dot;
  logic row_ok, col_ok;
  logic [1:0] ri, ci;

  always_comb begin
    ctr_idx = job_r.rc_low ? (job_r.cc_right ? 4'd8 : 4'd7)
                           : (job_r.cc_right ? 4'd5 : 4'd4);
    ctr = job_r.win[ctr_idx];
    nb  = job_r.win[idx_r];
    cx  = vx_of(ctr);
    cy  = vy_of(ctr);
    nx  = vx_of(nb);
    ny  = vy_of(nb);
    dot = 34'(nx * cx) + 34'(ny * cy);
    unique case (idx_r) inside
      4'd0, 4'd1, 4'd2: ri = 2'd0;
      4'd3, 4'd4, 4'd5: ri = 2'd1;
      default:          ri = 2'd2;
    endcase
    unique case (idx_r) inside
      4'd0, 4'd3, 4'd6: ci = 2'd0;
      4'd1, 4'd4, 4'd7: ci = 2'd1;
      default:          ci = 2'd2;
    endcase
    row_ok = (ri == 2'd2) || (ri == 2'd1 && job_r.rlo_mid) || (ri == 2'd0 && job_r.rlo_top);
    col_ok = (ci == 2'd2) || (ci == 2'd1 && job_r.clo_m) || (ci == 2'd0 && job_r.clo_l);
  end

  // one result bit per cycle: is (2n-1)^2 * len <= mag^2 * 2^(2F+2)
  // (2n-1)^2 * len is kept as a running sum of shifted terms
  logic [MagW-1:0] trial;
  logic [LenW-1:0] sqx_c, sqy_c, len_c;
  logic [AccW-1:0] ptry, sb_acc;
  logic            take;
  always_comb begin
    sqx_c  = LenW'(ax_r * ax_r);
    sqy_c  = LenW'(ay_r * ay_r);
    len_c  = sqx_c + sqy_c;
    trial  = res_r | (MagW'(1) << bit_r);
    ptry   = pacc_r + sb_r + lq_r;
    take   = (trial <= MagW'(1 << FracBits)) && (ptry <= rhs_r);
    sb_acc = take ? sb_r + (lq_r << 1) : sb_r;
  end

  function automatic logic [15:0] sgn(input logic neg, input logic [MagW-1:0] m);
    sgn = neg ? 16'(-{1'b0, m}) : 16'(m);
  endfunction

  assign job_ready        = (state_r == ST_IDLE);
  assign out_valid        = (state_r == ST_OUT);
  assign out_x            = ox_r;
  assign out_y            = oy_r;
  assign out_last_in_run  = job_r.last;
  assign out_end_of_frame = job_r.eof;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: if (job_valid) begin
          job_r   <= job;
          idx_r   <= '0;
          ax_r    <= '0;
          ay_r    <= '0;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (row_ok && col_ok) begin
            if (dot < 0) begin
              ax_r <= ax_r - SumW'(nx);
              ay_r <= ay_r - SumW'(ny);
            end else begin
              ax_r <= ax_r + SumW'(nx);
              ay_r <= ay_r + SumW'(ny);
            end
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == 4'd8) state_r <= ST_LEN;
        end
        ST_LEN: begin
          len_r   <= len_c;
          sqy_r   <= sqy_c;
          pacc_r  <= AccW'(len_c);
          sb_r    <= -(AccW'(len_c) << (MagW + 1));
          lq_r    <= AccW'(len_c) << (2 * MagW);
          rhs_r   <= AccW'(sqx_c) << (2 * FracBits + 2);
          res_r   <= '0;
          bit_r   <= CntW'(MagW - 1);
          state_r <= ST_NX;
        end
        ST_NX, ST_NY: begin
          if (len_r == '0 || len_r < LenW'(thresh)) begin
            ox_r    <= ctr[15:0];
            oy_r    <= ctr[31:16];
            state_r <= ST_OUT;
          end else if (bit_r != '0) begin
            bit_r <= bit_r - 1'b1;
            if (take) begin
              res_r  <= trial;
              pacc_r <= ptry;
            end
            sb_r <= AccW'($signed(sb_acc) >>> 1);
            lq_r <= lq_r >> 2;
          end else if (state_r == ST_NX) begin
            rx_r    <= take ? trial : res_r;
            res_r   <= '0;
            bit_r   <= CntW'(MagW - 1);
            pacc_r  <= AccW'(len_r);
            sb_r    <= -(AccW'(len_r) << (MagW + 1));
            lq_r    <= AccW'(len_r) << (2 * MagW);
            rhs_r   <= AccW'(sqy_r) << (2 * FracBits + 2);
            state_r <= ST_NY;
          end else begin
            ox_r    <= sgn(ax_r[SumW-1], rx_r);
            oy_r    <= sgn(ay_r[SumW-1], take ? trial : res_r);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: if (out_ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/sign_aligned_vector_smooth_3x3_unit.sv]
// top level of the sign-aligned 3x3 vector smoother
// One request (vec_x, vec_y) enters, raster order; it yields zero to four smoothed
// unit vectors for pixels whose lower-right neighbor it completes. The front side
// takes a new input only once it has queued every result of the last one; each result
// then passes through the back unit (one accept step, 9 neighbor accumulate steps, one
// length step, 15 bit-serial root steps per component and one output step), and the
// root steps are skipped when the center passes through. The back unit takes a new
// request only after its output has been taken.
// Line stores need no clearing pass; unwritten entries never reach a result.
module sign_aligned_vector_smooth_3x3_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [savs_pkg::CfgW-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_vec_x,
  input  logic [15:0] in_vec_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_out_x,
  output logic [15:0] out_out_y,
  output logic        out_last_in_run,
  output logic        out_end_of_frame
);
  import savs_pkg::*;

  logic [ThrW-1:0] thr_r;
  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= ThrW'(1);
    else if (cfg_we && cfg_idx == REG_THRESH) thr_r <= cfg_data[ThrW-1:0];
  end

  savs_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid, .in_ready, .in_vec_x, .in_vec_y,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  savs_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  savs_back u_back (
    .clk, .rst_n, .thresh(thr_r),
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_ready, .out_x(out_out_x), .out_y(out_out_y),
    .out_last_in_run, .out_end_of_frame
  );

endmodule

[test/sign_aligned_vector_smooth_3x3_unit_tb.sv]
// testbench for the sign-aligned 3x3 vector smoother: directed and random frames, scoreboard
module sign_aligned_vector_smooth_3x3_unit_tb;
  import savs_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int HalfPeriod = 6;
  localparam int DrainCycles = 300;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic        eof;
  } smooth_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_vec_x = '0;
  logic [15:0] in_vec_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_out_x, out_out_y;
  logic out_last_in_run, out_end_of_frame;

  sign_aligned_vector_smooth_3x3_unit i_dut (.*);

  always #HalfPeriod clk = ~clk;

  // shadow state of the smoother
  logic [FwW-1:0]  frame_w = 12'd640;
  logic [FhW-1:0]  frame_h = 13'd480;
  logic [ThrW-1:0] thresh = 16'd1;
  pix_t rows_mem [2*MaxWidth];
  pix_t win [9];
  int unsigned col_pos, row_pos;

  smooth_res_t pending_results[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet_send = 0;
  bit quiet_recv = 0;
  int stall_left = 0;
  logic [15:0] thresh_vals [3] = '{16'hffff, 16'h0000, 16'd900};

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [15:0] unit_mag(longint unsigned mag, longint unsigned len2);
    logic [127:0] rhs, lhs;
    longint unsigned lo, hi, n, t;
    lo = 0;
    hi = 64'd1 << FracBits;
    rhs = 128'(mag * mag) << (2 * FracBits + 2);
    while (lo < hi) begin
      n = (lo + hi + 1) / 2;
      t = 2 * n - 1;
      lhs = 128'(t * t) * 128'(len2);
      if (lhs <= rhs) lo = n;
      else hi = n - 1;
    end
    return lo[15:0];
  endfunction

  function automatic void smooth_at(int rlo, int rc, int clo, int cc, bit last, bit eof);
    pix_t cv;
    longint rx, ry, vx, vy, ax, ay;
    longint unsigned len2;
    smooth_res_t r;
    cv = win[rc*3+cc];
    rx = sx16(cv[15:0]);
    ry = sx16(cv[31:16]);
    ax = 0;
    ay = 0;
    for (int i = rlo; i <= 2; i++)
      for (int j = clo; j <= 2; j++) begin
        vx = sx16(win[i*3+j][15:0]);
        vy = sx16(win[i*3+j][31:16]);
        if (vx * rx + vy * ry < 0) begin
          vx = -vx;
          vy = -vy;
        end
        ax += vx;
        ay += vy;
      end
    len2 = longint'(ax * ax + ay * ay);
    if (len2 == 0 || len2 < longint'(thresh)) begin
      r.x = cv[15:0];
      r.y = cv[31:16];
    end else begin
      r.x = unit_mag(ax < 0 ? -ax : ax, len2);
      r.y = unit_mag(ay < 0 ? -ay : ay, len2);
      if (ax < 0) r.x = -r.x;
      if (ay < 0) r.y = -r.y;
    end
    r.last = last;
    r.eof = eof;
    pending_results.push_back(r);
  endfunction

  function automatic void advance_window(logic [15:0] vx, logic [15:0] vy);
    int unsigned w, h, c, r;
    pix_t cur, top, mid;
    int n_before;
    w = frame_w == 0 ? 1 : (frame_w > MaxWidth ? MaxWidth : frame_w);
    h = frame_h == 0 ? 1 : (frame_h > MaxHeight ? MaxHeight : frame_h);
    c = col_pos >= w ? w - 1 : col_pos;
    r = row_pos >= h ? h - 1 : row_pos;
    cur = {vy, vx};
    top = rows_mem[MaxWidth + c];
    mid = rows_mem[c];
    rows_mem[MaxWidth + c] = mid;
    rows_mem[c] = cur;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = cur;
    n_before = pending_results.size();
    if (r >= 1) begin
      if (c >= 1) smooth_at(r >= 2 ? 0 : 1, 1, c >= 2 ? 0 : 1, 1, 0, 0);
      if (c == w - 1) smooth_at(r >= 2 ? 0 : 1, 1, c >= 1 ? 1 : 2, 2, 0, 0);
    end
    if (r == h - 1) begin
      if (c >= 1) smooth_at(r >= 1 ? 1 : 2, 2, c >= 2 ? 0 : 1, 1, 0, 0);
      if (c == w - 1) smooth_at(r >= 1 ? 1 : 2, 2, c >= 1 ? 1 : 2, 2, 0, 1);
    end
    if (pending_results.size() > n_before)
      pending_results[pending_results.size()-1].last = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_vec(logic [15:0] vx, logic [15:0] vy);
    int gap;
    gap = quiet_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vec_x <= vx;
    in_vec_y <= vy;
    do @(posedge clk); while (!in_ready);
    advance_window(vx, vy);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH, REG_HEIGHT: begin
        if (idx == REG_WIDTH) frame_w = val[FwW-1:0];
        else frame_h = val[FhW-1:0];
        col_pos = 0;
        row_pos = 0;
        foreach (win[k]) win[k] = '0;
      end
      REG_THRESH: thresh = val;
      default: ;
    endcase
  endtask

  task automatic set_frame(int w, int h);
    write_reg(REG_WIDTH, CfgW'(w));
    write_reg(REG_HEIGHT, CfgW'(h));
  endtask

  function automatic logic [15:0] rand_comp();
    int p;
    p = $urandom_range(99);
    if (p < 80) return 16'($signed($urandom_range(32768)) - 16384);
    if (p < 90) return 16'($urandom);
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic test_directed();
    set_frame(3, 3);
    write_reg(REG_THRESH, 16'd1);
    send_vec(16'h4000, 16'h0000);
    send_vec(16'hc000, 16'h0000);
    send_vec(16'h8000, 16'h8000);
    send_vec(16'h7fff, 16'h7fff);
    send_vec(16'h0000, 16'h0000);
    send_vec(16'h0000, 16'h4000);
    send_vec(16'h2d41, 16'hd2bf);
    send_vec(16'hffff, 16'h0001);
    send_vec(16'h0000, 16'hc000);
    wait_idle();
    set_frame(1, 1);
    send_vec(16'h1234, 16'h8000);
    send_vec(16'h0000, 16'h0000);
    wait_idle();
    set_frame(0, 2);
    send_vec(16'h4000, 16'h0001);
    send_vec(16'hc000, 16'h0002);
    wait_idle();
    set_frame(4, 1);
    repeat (4) send_vec(16'h0003, 16'hfffc);
    wait_idle();
  endtask

  task automatic test_threshold();
    set_frame(3, 2);
    foreach (thresh_vals[k]) begin
      write_reg(REG_THRESH, thresh_vals[k]);
      repeat (6) send_vec(16'($signed($urandom_range(60)) - 30),
                          16'($signed($urandom_range(60)) - 30));
      wait_idle();
    end
  endtask

  task automatic test_size_extremes();
    write_reg(RegUnused, 16'hffff);
    write_reg(REG_WIDTH, 16'h0fff);
    write_reg(REG_HEIGHT, 16'h1fff);
    repeat (5) send_vec(rand_comp(), rand_comp());
    wait_idle();
    set_frame(2048, 1);
    quiet_send = 1;
    repeat (40) send_vec(rand_comp(), rand_comp());
    quiet_send = 0;
    wait_idle();
  endtask

  task automatic test_random_frames();
    int w, h, n;
    for (int f = 0; f < 14; f++) begin
      w = $urandom_range(7, 1);
      h = $urandom_range(5, 1);
      if ($urandom_range(3) == 0) write_reg(REG_THRESH, 16'($urandom_range(65535)));
      else write_reg(REG_THRESH, 16'($urandom_range(2)));
      set_frame(w, h);
      quiet_send = (f % 6) == 5;
      quiet_recv = (f % 6) == 5;
      n = w * h * $urandom_range(2, 1) + $urandom_range(w);
      for (int i = 0; i < n && i < 40; i++) begin
        if ($urandom_range(9) == 0)
          send_vec(16'($signed($urandom_range(40)) - 20), 16'($signed($urandom_range(40)) - 20));
        else
          send_vec(rand_comp(), rand_comp());
      end
      quiet_send = 0;
      quiet_recv = 0;
      wait_idle();
    end
  endtask

  // result side backpressure: mostly short gaps, now and then a long stall
  always @(posedge clk) begin
    if (!rst_n || quiet_recv) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) == 0) begin
      stall_left = $urandom_range(60, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(4) != 0;
    end
  end

  always @(posedge clk) begin
    smooth_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result x=%h y=%h", out_out_x, out_out_y);
      end else begin
        e = pending_results.pop_front();
        if (e.x !== out_out_x || e.y !== out_out_y || e.last !== out_last_in_run ||
            e.eof !== out_end_of_frame) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp x=%h y=%h last=%b eof=%b got x=%h y=%h last=%b eof=%b",
                     e.x, e.y, e.last, e.eof, out_out_x, out_out_y, out_last_in_run,
                     out_end_of_frame);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    col_pos = 0;
    row_pos = 0;
    foreach (win[k]) win[k] = '0;
    foreach (rows_mem[k]) rows_mem[k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_threshold();
    test_size_extremes();
    test_random_frames();
    wait_idle();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
